### rtl/rlpu_pkg.sv
// ---------------------------------------------------------------------------
// rlpu_pkg
// Shared types, constants and pair rule tables for the ring lattice pair
// update unit.
// ---------------------------------------------------------------------------
package rlpu_pkg;

  localparam int SITES_DEF   = 1024;
  localparam int RING_W      = 11;
  localparam int THR_W       = 17;
  localparam int IDX_W       = 10;
  localparam int DRAW_W      = 16;
  localparam int COUNT_W     = 11;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 24;

  localparam logic [RING_W-1:0] RING_SIZE_RST = 11'd1024;
  localparam logic [THR_W-1:0]  ALPHA_RST     = 17'd9175;
  localparam logic [THR_W-1:0]  BETA_RST      = 17'd1311;
  localparam logic [THR_W-1:0]  GAMMA_RST     = 17'd58982;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_RING_SIZE = 2'd0,
    CFG_ALPHA     = 2'd1,
    CFG_BETA      = 2'd2,
    CFG_GAMMA     = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    RK_NONE  = 3'd0,
    RK_ALPHA = 3'd1,
    RK_BETA  = 3'd2,
    RK_GAMMA = 3'd3,
    RK_SPLIT = 3'd4
  } rule_kind_t;

  localparam logic [3:0] SPLIT_BETA_CODE = 4'h8;

  typedef struct packed {
    logic latch_item;
    logic rd_j;
    logic clr_write;
    logic ld_write;
    logic wr_i;
    logic wr_j;
    logic out_load;
  } rlpu_cmd_t;

  typedef struct packed {
    logic rejected;
    logic op_update;
    logic clr_last;
    logic out_free;
  } rlpu_sts_t;

  function automatic rule_kind_t rule_kind(input logic [3:0] code);
    rule_kind_t k;
    case (code)
      4'd3, 4'd7, 4'd15:  k = RK_BETA;
      4'd6, 4'd14:        k = RK_GAMMA;
      4'd8, 4'd9, 4'd10:  k = RK_ALPHA;
      4'd11:              k = RK_SPLIT;
      default:            k = RK_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] rule_next(input logic [3:0] code);
    logic [3:0] n;
    case (code)
      4'd3:    n = 4'h0;
      4'd6:    n = 4'h3;
      4'd7:    n = 4'h4;
      4'd8:    n = 4'hC;
      4'd9:    n = 4'hD;
      4'd10:   n = 4'hE;
      4'd11:   n = 4'hF;
      4'd14:   n = 4'hB;
      4'd15:   n = 4'hC;
      default: n = code;
    endcase
    return n;
  endfunction

endpackage

### rtl/rlpu_ram.sv
// ---------------------------------------------------------------------------
// rlpu_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module rlpu_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rlpu_ctrl.sv
// ---------------------------------------------------------------------------
// rlpu_ctrl
// Sequencer: clearing sweep after reset, then per transaction the site
// reads, load or rule write-backs and result hand-off.
// ---------------------------------------------------------------------------
module rlpu_ctrl
  import rlpu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  rlpu_sts_t sts,
  output rlpu_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_RDI  = 8'b0000_0100,
    S_RDJ  = 8'b0000_1000,
    S_WRI  = 8'b0001_0000,
    S_WRJ  = 8'b0010_0000,
    S_LDW  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = S_RDI;
        end
      end
      S_RDI: begin
        if (sts.rejected) begin
          state_nxt = S_DONE;
        end else if (sts.op_update) begin
          state_nxt = S_RDJ;
        end else begin
          state_nxt = S_LDW;
        end
      end
      S_RDJ: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_WRI;
      end
      S_WRI: begin
        cmd.wr_i  = 1'b1;
        state_nxt = S_WRJ;
      end
      S_WRJ: begin
        cmd.wr_j  = 1'b1;
        state_nxt = S_DONE;
      end
      S_LDW: begin
        cmd.ld_write = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

### rtl/rlpu_dp.sv
// ---------------------------------------------------------------------------
// rlpu_dp
// Datapath: config registers, item registers, site memory, pair rule
// evaluation, running totals and the result register.
// ---------------------------------------------------------------------------
module rlpu_dp
  import rlpu_pkg::*;
#(
  parameter int SITES = SITES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_op,
  input  logic [IDX_W-1:0]       in_site_index,
  input  logic                   in_load_a,
  input  logic                   in_load_b,
  input  logic [DRAW_W-1:0]      in_draw_one,
  input  logic [DRAW_W-1:0]      in_draw_two,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [COUNT_W-1:0]     out_count_a,
  output logic [COUNT_W-1:0]     out_count_b,
  output logic                   out_rejected,
  input  rlpu_cmd_t              cmd,
  output rlpu_sts_t              sts
);

  localparam int AW = $clog2(SITES);
  localparam int NW = $clog2(SITES + 1);
  localparam int CW = (NW > RING_W) ? NW : RING_W;

  // config
  logic [RING_W-1:0] ring_size_r;
  logic [THR_W-1:0]  alpha_thr_r, beta_thr_r, gamma_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      alpha_thr_r <= ALPHA_RST;
      beta_thr_r  <= BETA_RST;
      gamma_thr_r <= GAMMA_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_RING_SIZE: ring_size_r <= cfg_wdata[RING_W-1:0];
        CFG_ALPHA:     alpha_thr_r <= cfg_wdata[THR_W-1:0];
        CFG_BETA:      beta_thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_GAMMA:     gamma_thr_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // item
  logic              op_r, la_r, lb_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DRAW_W-1:0] d1_r, d2_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      op_r  <= in_op;
      idx_r <= in_site_index;
      la_r  <= in_load_a;
      lb_r  <= in_load_b;
      d1_r  <= in_draw_one;
      d2_r  <= in_draw_two;
    end
  end

  // ring geometry
  logic [CW-1:0] ring_ext, n_eff, idx_ext, idx_inc, j_ext;
  logic [AW-1:0] addr_i, addr_j;
  logic          rej;

  always_comb begin
    ring_ext = CW'(ring_size_r);
    if (ring_ext < CW'(2)) begin
      n_eff = CW'(2);
    end else if (ring_ext > CW'(SITES)) begin
      n_eff = CW'(SITES);
    end else begin
      n_eff = ring_ext;
    end
    idx_ext = CW'(idx_r);
    idx_inc = idx_ext + CW'(1);
    j_ext   = (idx_inc == n_eff) ? '0 : idx_inc;
    rej     = (idx_ext >= n_eff);
    addr_i  = idx_ext[AW-1:0];
    addr_j  = j_ext[AW-1:0];
  end

  // clearing sweep
  logic [AW-1:0] clr_cnt_r;
  logic          clr_last;

  assign clr_last = (clr_cnt_r == AW'(SITES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_write) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // site memory, word = {a, b}
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_wdata, ram_rdata;

  rlpu_ram #(
    .WIDTH (2),
    .DEPTH (SITES)
  ) u_sites (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = cmd.rd_j ? addr_j : addr_i;

  // pair rule
  logic [1:0]  old_i_r, old_j_r, new_j_r;
  logic        fire_r;
  logic [3:0]  code, nk;
  rule_kind_t  kind;
  logic        fire;
  logic        lt_alpha, lt_beta1, lt_beta2, lt_gamma;

  always_comb begin
    code     = {old_i_r[1], ram_rdata[1], old_i_r[0], ram_rdata[0]};
    kind     = rule_kind(code);
    nk       = rule_next(code);
    lt_alpha = {1'b0, d1_r} < alpha_thr_r;
    lt_beta1 = {1'b0, d1_r} < beta_thr_r;
    lt_beta2 = {1'b0, d2_r} < beta_thr_r;
    lt_gamma = {1'b0, d1_r} < gamma_thr_r;
    fire     = 1'b0;
    case (kind)
      RK_ALPHA: fire = lt_alpha;
      RK_BETA:  fire = lt_beta1;
      RK_GAMMA: fire = lt_gamma;
      RK_SPLIT: begin
        if (lt_alpha) begin
          fire = 1'b1;
        end else if (lt_beta2) begin
          fire = 1'b1;
          nk   = SPLIT_BETA_CODE;
        end
      end
      default: fire = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_j) begin
      old_i_r <= ram_rdata;
    end
    if (cmd.wr_i) begin
      old_j_r <= ram_rdata;
      new_j_r <= {nk[2], nk[0]};
      fire_r  <= fire;
    end
  end

  // write port and totals
  logic          upd_en;
  logic [1:0]    upd_old, upd_new;
  logic [NW-1:0] total_a_r, total_a_nxt, total_b_r, total_b_nxt;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_i;
    ram_wdata = '0;
    upd_en    = 1'b0;
    upd_old   = ram_rdata;
    upd_new   = '0;
    if (cmd.clr_write) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (cmd.ld_write) begin
      ram_we    = 1'b1;
      ram_wdata = {la_r, lb_r};
      upd_en    = 1'b1;
      upd_new   = {la_r, lb_r};
    end else if (cmd.wr_i) begin
      ram_we    = fire;
      ram_wdata = {nk[3], nk[1]};
      upd_en    = fire;
      upd_old   = old_i_r;
      upd_new   = {nk[3], nk[1]};
    end else if (cmd.wr_j) begin
      ram_we    = fire_r;
      ram_waddr = addr_j;
      ram_wdata = new_j_r;
      upd_en    = fire_r;
      upd_old   = old_j_r;
      upd_new   = new_j_r;
    end

    total_a_nxt = total_a_r;
    total_b_nxt = total_b_r;
    if (upd_en && (upd_new[1] != upd_old[1])) begin
      total_a_nxt = upd_new[1] ? total_a_r + NW'(1) : total_a_r - NW'(1);
    end
    if (upd_en && (upd_new[0] != upd_old[0])) begin
      total_b_nxt = upd_new[0] ? total_b_r + NW'(1) : total_b_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_a_r <= '0;
      total_b_r <= '0;
    end else begin
      total_a_r <= total_a_nxt;
      total_b_r <= total_b_nxt;
    end
  end

  // result register
  logic                 out_tvalid_r;
  logic [COUNT_W-1:0]   cnt_a_r, cnt_b_r;
  logic                 rej_out_r;
  logic [CW-1:0]        tot_a_ext, tot_b_ext;
  logic [COUNT_W-1:0]   sat_a, sat_b;

  always_comb begin
    tot_a_ext = CW'(total_a_r);
    tot_b_ext = CW'(total_b_r);
    sat_a = (tot_a_ext > CW'(2047)) ? {COUNT_W{1'b1}} : tot_a_ext[COUNT_W-1:0];
    sat_b = (tot_b_ext > CW'(2047)) ? {COUNT_W{1'b1}} : tot_b_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cnt_a_r   <= sat_a;
      cnt_b_r   <= sat_b;
      rej_out_r <= rej;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_count_a  = cnt_a_r;
  assign out_count_b  = cnt_b_r;
  assign out_rejected = rej_out_r;

  assign sts.rejected  = rej;
  assign sts.op_update = op_r;
  assign sts.clr_last  = clr_last;
  assign sts.out_free  = !out_tvalid_r || out_tready;

endmodule

### rtl/ring_lattice_pair_update_unit.sv
// ---------------------------------------------------------------------------
// ring_lattice_pair_update_unit
// Two-bit-per-site ring with running totals; load and pair update stream.
// ---------------------------------------------------------------------------
// After reset the site memory is swept to zero, one site per cycle, so no
// transaction is taken until the sweep has reached the last site (config
// writes still go in). A rejected index goes straight to the hand-off, a
// load reads site i and then writes it, and a pair update uses the single
// read and single write port of the site memory in turn (read i, read j,
// write i, write j). The result sits in an output register, so the next
// transaction is accepted while it waits to be taken.
module ring_lattice_pair_update_unit
  import rlpu_pkg::*;
#(
  parameter int SITES = SITES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] site_index, [10] load_a, [11] load_b, [27:12] draw_one,
  // [43:28] draw_two, [47:44] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // [0] op
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [10:0] count_a, [21:11] count_b, [23:22] zero
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // [0] rejected
  output logic                   out_tuser
);

  rlpu_cmd_t          cmd;
  rlpu_sts_t          sts;
  logic [COUNT_W-1:0] count_a, count_b;

  rlpu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlpu_dp #(
    .SITES (SITES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_op         (in_tuser),
    .in_site_index (in_tdata[9:0]),
    .in_load_a     (in_tdata[10]),
    .in_load_b     (in_tdata[11]),
    .in_draw_one   (in_tdata[27:12]),
    .in_draw_two   (in_tdata[43:28]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_count_a   (count_a),
    .out_count_b   (count_b),
    .out_rejected  (out_tuser),
    .cmd           (cmd),
    .sts           (sts)
  );

  assign out_tdata = {2'b00, count_b, count_a};

endmodule
